FILE: hw/rtl/srfp_pkg.sv
// ----------------------------------------------------------------------------
// srfp_pkg
// Types, codes and the CRC-16/MODBUS byte update for the status report
// frame parser.
// ----------------------------------------------------------------------------
package srfp_pkg;

  localparam int NUM_VALUES = 7;

  localparam logic [7:0] SYNC_BYTE       = 8'hFE;
  localparam logic [7:0] CMD_SPEED_ACK   = 8'h21;
  localparam logic [7:0] CMD_AUTO_ACK    = 8'h23;
  localparam logic [7:0] CMD_REPORT      = 8'h25;
  localparam logic [7:0] MIN_REPORT_LEN  = 8'd3;
  localparam logic [7:0] FULL_REPORT_LEN = 8'd11;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_SYNC1,
    PH_LEN,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SPEED_ACK,
    KIND_AUTO_ACK,
    KIND_REPORT,
    KIND_UNKNOWN
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_CMD,
    ST_SHORT,
    ST_CRC_ERR
  } status_t;

  typedef logic [NUM_VALUES-1:0][7:0] values_t;

  typedef struct packed {
    kind_t   kind;
    status_t status;
    logic    updated;
    values_t values;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  localparam logic [15:0] CRC_AFTER_SYNC = crc_feed(crc_feed(CRC_INIT, SYNC_BYTE), SYNC_BYTE);

endpackage

FILE: hw/rtl/srfp_rx_if.sv
// ----------------------------------------------------------------------------
// srfp_rx_if
// Received byte channel: one serial byte per request.
// ----------------------------------------------------------------------------
interface srfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: hw/rtl/srfp_res_if.sv
// ----------------------------------------------------------------------------
// srfp_res_if
// Frame result channel: one request per completed frame.
// ----------------------------------------------------------------------------
interface srfp_res_if;
  logic              valid;
  logic              ready;
  logic [1:0]        frame_kind;
  logic [1:0]        frame_status;
  logic              values_updated;
  logic signed [7:0] speed_x;
  logic signed [7:0] speed_y;
  logic signed [7:0] turn_rate;
  logic [7:0]        motor_state;
  logic [7:0]        motor_fault;
  logic [7:0]        battery_tenths;
  logic [7:0]        enable_state;

  modport source (
    output valid, output frame_kind, output frame_status, output values_updated,
    output speed_x, output speed_y, output turn_rate, output motor_state,
    output motor_fault, output battery_tenths, output enable_state,
    input ready
  );
  modport sink (
    input valid, input frame_kind, input frame_status, input values_updated,
    input speed_x, input speed_y, input turn_rate, input motor_state,
    input motor_fault, input battery_tenths, input enable_state,
    output ready
  );
endinterface

FILE: hw/rtl/srfp_parser.sv
// ----------------------------------------------------------------------------
// srfp_parser
// Frame state, running CRC and report value store; takes one byte per step
// and flags a completed frame together with its result.
// ----------------------------------------------------------------------------
module srfp_parser import srfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output logic       done,
  output result_t    result
);

  phase_t          phase, phase_next;
  logic [7:0]      frame_length, frame_length_next;
  logic [7:0]      bytes_left, bytes_left_next;
  logic [15:0]     crc, crc_next;
  logic [1:0][7:0] held, held_next;
  logic [7:0]      command_code, command_code_next;
  values_t         capture, capture_next;
  values_t         report_values, report_values_next;

  logic [7:0]  k;
  logic [7:0]  left_dec;
  logic [2:0]  cap_idx;
  logic [15:0] rx_crc;

  assign k        = frame_length - bytes_left;
  assign left_dec = bytes_left - 8'd1;
  assign cap_idx  = 3'(k - 8'd1);

  always_comb begin
    phase_next         = phase;
    frame_length_next  = frame_length;
    bytes_left_next    = bytes_left;
    crc_next           = crc;
    held_next          = held;
    command_code_next  = command_code;
    capture_next       = capture;
    report_values_next = report_values;
    rx_crc             = 16'h0000;
    done               = 1'b0;
    result.kind        = KIND_UNKNOWN;
    result.status      = ST_OK;
    result.updated     = 1'b0;

    case (phase)
      PH_HUNT: begin
        if (rx_byte == SYNC_BYTE) phase_next = PH_SYNC1;
      end
      PH_SYNC1: begin
        if (rx_byte == SYNC_BYTE) begin
          phase_next = PH_LEN;
          crc_next   = CRC_AFTER_SYNC;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_LEN: begin
        frame_length_next = rx_byte;
        bytes_left_next   = rx_byte;
        crc_next          = crc_feed(crc, rx_byte);
        held_next         = '0;
        if (rx_byte == 8'd0) begin
          done          = 1'b1;
          result.kind   = KIND_UNKNOWN;
          result.status = ST_SHORT;
        end else begin
          phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        if (k == 8'd0) command_code_next = rx_byte;
        if (k inside {[8'd1:8'd7]}) capture_next[cap_idx] = rx_byte;
        if (k >= 8'd2) crc_next = crc_feed(crc, held[0]);
        held_next[0]    = held[1];
        held_next[1]    = rx_byte;
        bytes_left_next = left_dec;
        rx_crc          = {held_next[0], held_next[1]};
        if (left_dec == 8'd0) begin
          done = 1'b1;
          if (command_code_next == CMD_SPEED_ACK) begin
            result.kind = KIND_SPEED_ACK;
          end else if (command_code_next == CMD_AUTO_ACK) begin
            result.kind = KIND_AUTO_ACK;
          end else if (command_code_next != CMD_REPORT) begin
            result.kind   = KIND_UNKNOWN;
            result.status = ST_BAD_CMD;
          end else begin
            result.kind = KIND_REPORT;
            if (frame_length < MIN_REPORT_LEN) begin
              result.status = ST_SHORT;
            end else if (rx_crc != crc_next) begin
              result.status = ST_CRC_ERR;
            end else if (frame_length >= FULL_REPORT_LEN) begin
              result.updated     = 1'b1;
              report_values_next = capture_next;
            end
          end
        end
      end
      default: phase_next = PH_HUNT;
    endcase

    if (done) begin
      phase_next = PH_HUNT;
      crc_next   = CRC_INIT;
    end
    result.values = report_values_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      frame_length  <= 8'd0;
      bytes_left    <= 8'd0;
      crc           <= CRC_INIT;
      held          <= '0;
      command_code  <= 8'd0;
      report_values <= '0;
    end else if (step) begin
      phase         <= phase_next;
      frame_length  <= frame_length_next;
      bytes_left    <= bytes_left_next;
      crc           <= crc_next;
      held          <= held_next;
      command_code  <= command_code_next;
      report_values <= report_values_next;
    end
  end

  // capture entries are always written within a frame before commit
  always_ff @(posedge clk) begin
    if (step) capture <= capture_next;
  end

endmodule

FILE: hw/rtl/status_report_frame_parser.sv
// ----------------------------------------------------------------------------
// status_report_frame_parser
// Sync hunting, length-framed command parser with CRC-16/MODBUS check on
// status reports and a store of the last committed report values.
// ----------------------------------------------------------------------------
// Takes one received byte per clock when the result side keeps up: a byte
// passes an input register, one pass through the parser (frame state and an
// eight-step CRC byte update) and, if it ends a frame, lands in the result
// register. The single per-byte parser pass sets the rate of one byte a
// cycle; a held result stalls the parser only while a byte is waiting behind
// it. The value fields always show the committed report values as of the
// frame that produced the result.
module status_report_frame_parser import srfp_pkg::*; (
  input logic     clk,
  input logic     rst,
  srfp_rx_if.sink   rx,
  srfp_res_if.source res
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  logic       done;
  result_t    result;
  logic       res_valid;
  result_t    res_q;

  assign advance  = in_valid && (!res_valid || res.ready);
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) in_byte <= rx.rx_byte;
  end

  srfp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .done    (done),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && done) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && done) res_q <= result;
  end

  assign res.valid          = res_valid;
  assign res.frame_kind     = res_q.kind;
  assign res.frame_status   = res_q.status;
  assign res.values_updated = res_q.updated;
  assign res.speed_x        = $signed(res_q.values[0]);
  assign res.speed_y        = $signed(res_q.values[1]);
  assign res.turn_rate      = $signed(res_q.values[2]);
  assign res.motor_state    = res_q.values[3];
  assign res.motor_fault    = res_q.values[4];
  assign res.battery_tenths = res_q.values[5];
  assign res.enable_state   = res_q.values[6];

  a_update_only_good_report: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.values_updated |->
      res.frame_kind == KIND_REPORT && res.frame_status == ST_OK)
    else $error("value commit on a frame that is not a good report");

  a_unknown_never_ok: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.frame_kind == KIND_UNKNOWN |-> res.frame_status != ST_OK)
    else $error("unknown frame reported as ok");

  a_stalled_byte_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("waiting byte lost from input register");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> rx.ready)
    else $error("input not ready with empty input register");

endmodule
